>>> rtl/core/dlns_pkg.sv
`timescale 1ns / 1ps
// dlns_pkg: shared types and constants for the decimal to lcd nibble stream block
// no dependencies

package dlns_pkg;

	// field widths
	localparam int NUM_W    = 16;
	localparam int BYTE_W   = 8;
	localparam int NIB_W    = 4;
	localparam int DIGITS   = 5;
	localparam int BCD_W    = DIGITS * NIB_W;
	localparam int CNT_W    = 5;
	localparam int DCNT_W   = 3;

	// upper nibble of an ascii digit character
	localparam logic [NIB_W-1:0] ASCII_DIGIT_HI = 4'h3;

	// configuration register indexes
	localparam logic [1:0] REG_DATA_SELECT = 2'd0;
	localparam logic [1:0] REG_ENABLE      = 2'd1;
	localparam logic [1:0] REG_BACKLIGHT   = 2'd2;

	// expander bit patterns
	typedef struct packed {
		logic [BYTE_W-1:0] data_select;
		logic [BYTE_W-1:0] enable;
		logic [BYTE_W-1:0] backlight;
	} mask_cfg_t;

	// converter to sequencer hand-off
	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} bcd_result_t;

endpackage

>>> rtl/core/dlns_bcd.sv
`timescale 1ns / 1ps
// dlns_bcd: bit-serial binary to bcd converter, one input bit per cycle
// depends on dlns_pkg

module dlns_bcd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dlns_pkg::NUM_W-1:0]    number,
	output logic                          busy,
	output dlns_pkg::bcd_result_t         result
);
	import dlns_pkg::*;

	logic [NUM_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BCD_W-1:0] bcd_adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*NIB_W +: NIB_W] >= NIB_W'(5))
				bcd_adj[d*NIB_W +: NIB_W] = bcd_q[d*NIB_W +: NIB_W] + NIB_W'(3);
			else
				bcd_adj[d*NIB_W +: NIB_W] = bcd_q[d*NIB_W +: NIB_W];
		end
	end

	// control: shift count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// shift register: binary bits move into the bcd digits msb first
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= number;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUM_W-1]};
		end
	end

	assign busy        = busy_q;
	assign result.done = done_q;
	assign result.bcd  = bcd_q;

endmodule

>>> rtl/core/dlns_emit.sv
`timescale 1ns / 1ps
// dlns_emit: walks the bcd digits msb first and emits three expander bytes per nibble
// depends on dlns_pkg

module dlns_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dlns_pkg::bcd_result_t          result,
	input  dlns_pkg::mask_cfg_t            masks,
	output logic                           active,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dlns_pkg::BYTE_W-1:0]    bus_byte,
	output logic                           last_byte
);
	import dlns_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [BCD_W-1:0]  dig_q;
	logic [DCNT_W-1:0] left_q;
	logic              half_q;
	logic [1:0]        step_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	logic              slot_free;
	logic [NIB_W-1:0]  nibble;
	logic [BYTE_W-1:0] plain;
	logic [BYTE_W-1:0] next_byte;
	logic              is_last;

	assign slot_free = !out_valid_q || !out_stall;

	// byte pattern for the current nibble and strobe step
	always_comb begin
		nibble = half_q ? dig_q[BCD_W-1 -: NIB_W] : ASCII_DIGIT_HI;
		plain  = {nibble, NIB_W'(0)} | masks.data_select | masks.backlight;
		case (step_q)
			2'd0:    next_byte = plain;
			2'd1:    next_byte = plain | masks.enable;
			default: next_byte = plain & ~masks.enable;
		endcase
		is_last = (left_q == DCNT_W'(1)) && half_q && (step_q == 2'd2);
	end

	// sequencer: leading zero skip, then digit, nibble and strobe counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_q      <= '0;
			half_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output beat valid: set on a new byte, cleared once taken
			if (state_q == ST_EMIT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (result.done) begin
						state_q <= ST_SKIP;
						left_q  <= DCNT_W'(DIGITS);
						half_q  <= 1'b0;
						step_q  <= '0;
					end
				end
				ST_SKIP: begin
					if (dig_q[BCD_W-1 -: NIB_W] == '0 && left_q != DCNT_W'(1))
						left_q <= left_q - DCNT_W'(1);
					else
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (step_q == 2'd2) begin
							step_q <= '0;
							half_q <= !half_q;
							if (half_q) begin
								left_q <= left_q - DCNT_W'(1);
								if (is_last)
									state_q <= ST_IDLE;
							end
						end else begin
							step_q <= step_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// digit shift register and output beat register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && result.done)
			dig_q <= result.bcd;
		else if (state_q == ST_SKIP && dig_q[BCD_W-1 -: NIB_W] == '0
				&& left_q != DCNT_W'(1))
			dig_q <= {dig_q[BCD_W-NIB_W-1:0], NIB_W'(0)};
		else if (state_q == ST_EMIT && slot_free && step_q == 2'd2 && half_q)
			dig_q <= {dig_q[BCD_W-NIB_W-1:0], NIB_W'(0)};
		if (state_q == ST_EMIT && slot_free) begin
			byte_q <= next_byte;
			last_q <= is_last;
		end
	end

	assign active    = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign bus_byte  = byte_q;
	assign last_byte = last_q;

endmodule

>>> rtl/core/decimal_to_lcd_nibble_stream.sv
`timescale 1ns / 1ps
// decimal_to_lcd_nibble_stream: top level, configuration registers and handshake
// depends on dlns_pkg, dlns_bcd, dlns_emit
//
// channel   direction  handshake           payload
// in        input      in_valid/in_stall    number[15:0]
// out       output     out_valid/out_stall  bus_byte[7:0], last_byte
// cfg       input      cfg_we               cfg_index[1:0], cfg_data[7:0]
//
// a number passes through the bit-serial converter and a registered hand-off,
// then the sequencer skips leading zeros and emits one byte per cycle while out_stall is low,
// 6 per digit, so 6 to 30 output beats per number.
// a new number is taken once converter and sequencer are idle, while the last beat may wait.
// reset restores the masks to 1, 4 and 8 and empties the output register.
// out_stall holds the output beat and pauses the sequencer.

module decimal_to_lcd_nibble_stream (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dlns_pkg::NUM_W-1:0]     number,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dlns_pkg::BYTE_W-1:0]    bus_byte,
	output logic                           last_byte,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [dlns_pkg::BYTE_W-1:0]    cfg_data
);
	import dlns_pkg::*;

	mask_cfg_t   masks_q;
	bcd_result_t conv_res;
	logic        conv_busy;
	logic        emit_active;
	logic        accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q.data_select <= BYTE_W'(1);
			masks_q.enable      <= BYTE_W'(4);
			masks_q.backlight   <= BYTE_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DATA_SELECT: masks_q.data_select <= cfg_data;
				REG_ENABLE:      masks_q.enable      <= cfg_data;
				REG_BACKLIGHT:   masks_q.backlight   <= cfg_data;
				default:         ;
			endcase
		end
	end

	// input beat taken only when converter, hand-off and sequencer are free
	assign in_stall = conv_busy || conv_res.done || emit_active;
	assign accept   = in_valid && !in_stall;

	dlns_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.number (number),
		.busy   (conv_busy),
		.result (conv_res)
	);

	dlns_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (conv_res),
		.masks     (masks_q),
		.active    (emit_active),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bus_byte  (bus_byte),
		.last_byte (last_byte)
	);

`ifndef SYNTH
	// converter and sequencer never work at the same time
	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(conv_busy && emit_active))
		else $error("converter and sequencer both busy");

	// an accepted number starts the converter
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> conv_busy)
		else $error("converter did not start");

	// the conversion result lands only in an idle sequencer
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		conv_res.done |-> !emit_active ##1 emit_active)
		else $error("sequencer not ready for conversion result");
`endif

endmodule
